>>> hdl/msq_pkg.sv
// ----------------------------------------------------------------------------
// Marching squares cell package
// Shared types and constants for the isoline cell unit.
// ----------------------------------------------------------------------------
`default_nettype none

package msq_pkg;

   // Number of corners, and of edges, in one cell.
   localparam int NUM_CORNERS = 4;

   // How the interpolation fraction of one edge is formed.
   typedef enum logic [1:0] {
      FM_ZERO = 2'd0,   // level at or before the start corner
      FM_HALF = 2'd1,   // flat edge, crossing placed at the middle
      FM_ONE  = 2'd2,   // level at or past the end corner
      FM_DIV  = 2'd3    // fraction comes from the divider
   } fmode_type;

endpackage

`default_nettype wire

>>> hdl/msq_div_pipe.sv
// ----------------------------------------------------------------------------
// Pipelined fraction divider
// Computes floor(num * 2^FB / den) for num < den, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module msq_div_pipe #(
   parameter int VB = 16,
   parameter int FB = 16
) (
   input  wire logic          clock,
   input  wire logic          en_i,
   input  wire logic [VB-1:0] num_i,
   input  wire logic [VB-1:0] den_i,
   output logic      [FB-1:0] quo_o
);

   logic [VB-1:0] rem_ff [FB];
   logic [VB-1:0] den_ff [FB];
   logic [FB-1:0] quo_ff [FB];
   logic [VB-1:0] rem_in [FB];
   logic [FB-1:0] quo_in [FB];

   always_comb begin
      logic [VB:0]   t;
      logic [VB-1:0] rp;
      logic [VB-1:0] dp;
      logic [FB-1:0] qp;
      for (int k = 0; k < FB; k++) begin
         if (k == 0) begin
            rp = num_i;
            dp = den_i;
            qp = '0;
         end else begin
            rp = rem_ff[k-1];
            dp = den_ff[k-1];
            qp = quo_ff[k-1];
         end
         t = {rp, 1'b0};
         if (t >= {1'b0, dp}) begin
            rem_in[k] = VB'(t - {1'b0, dp});
            quo_in[k] = {qp[FB-2:0], 1'b1};
         end else begin
            rem_in[k] = t[VB-1:0];
            quo_in[k] = {qp[FB-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_i) begin
         for (int k = 0; k < FB; k++) begin
            rem_ff[k] <= rem_in[k];
            quo_ff[k] <= quo_in[k];
            den_ff[k] <= (k == 0) ? den_i : den_ff[k-1];
         end
      end
   end

   assign quo_o = quo_ff[FB-1];

endmodule

`default_nettype wire

>>> hdl/marching_squares_cell_unit.sv
// Throughput: one cell per cycle; the fraction divider is a pipeline with one
// stage per quotient bit, and the whole pipeline holds when the result waits.
// Reset clears all valid bits and sets the contour level to zero.
// ----------------------------------------------------------------------------
// Marching squares cell unit
// Turns one grid cell into up to two ordered isoline segments.
// ----------------------------------------------------------------------------
`default_nettype none

module marching_squares_cell_unit
   import msq_pkg::*;
#(
   parameter int VALUE_BITS    = 16,
   parameter int COORD_BITS    = 16,
   parameter int FRACTION_BITS = 16,
   localparam int IN_BITS  = 4 * VALUE_BITS + 4 * COORD_BITS + 4,
   localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
   localparam int OUT_BITS = 8 * COORD_BITS + 3,
   localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [VALUE_BITS-1:0] csr_data,       // contour_level
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // corner_value_0..3, cell_x_low, cell_x_high, cell_y_low, cell_y_high,
   // corner_valid_mask, zero fill
   input  wire logic [IN_W-1:0]       req_tdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y, seg_b_start_x,
   // seg_b_start_y, seg_b_end_x, seg_b_end_y, segment_count, cell_supported,
   // zero fill
   output logic [OUT_W-1:0]           rsp_tdata
);

   localparam int VB = VALUE_BITS;
   localparam int CB = COORD_BITS;
   localparam int FB = FRACTION_BITS;
   localparam int PW = FB + 1 + CB;

   typedef struct packed {
      logic [3:0][CB-1:0] crd;     // x low, x high, y low, y high
      logic [3:0]         hi;
      logic               chi;
      logic               sup;
      fmode_type [3:0]    mode;
   } side_type;

   logic en;
   logic signed [VB-1:0] level_ff;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
      end else if (csr_valid) begin
         level_ff <= csr_data;
      end
   end

   logic rsp_vld_ff;
   assign en         = ~rsp_vld_ff | rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = rsp_vld_ff;

   // Stage 1: input capture.
   logic s1_vld_ff;
   logic signed [VB-1:0] s1_v_ff [4];
   logic [3:0][CB-1:0]   s1_crd_ff;
   logic                 s1_sup_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= req_tvalid;
      end
      if (en) begin
         for (int k = 0; k < NUM_CORNERS; k++) begin
            s1_v_ff[k]   <= req_tdata[k*VB +: VB];
            s1_crd_ff[k] <= req_tdata[4*VB + k*CB +: CB];
         end
         s1_sup_ff <= &req_tdata[4*VB + 4*CB +: 4];
      end
   end

   // Stage 2: corner classes, edge numerators and denominators.
   logic s2_vld_ff;
   side_type s2_side_ff, s2_side_in;
   logic [VB-1:0] s2_num_ff [4];
   logic [VB-1:0] s2_den_ff [4];
   logic [VB-1:0] s2_num_in [4];
   logic [VB-1:0] s2_den_in [4];

   always_comb begin
      logic signed [VB:0]   num, den;
      logic signed [VB+1:0] sum;
      logic signed [VB+2:0] lvl4;
      s2_side_in     = '0;
      s2_side_in.crd = s1_crd_ff;
      s2_side_in.sup = s1_sup_ff;
      sum = '0;
      for (int k = 0; k < NUM_CORNERS; k++) begin
         s2_side_in.hi[k] = s1_v_ff[k] >= level_ff;
         sum = sum + (VB+2)'(s1_v_ff[k]);
      end
      lvl4 = (VB+3)'(level_ff) <<< 2;
      s2_side_in.chi = (VB+3)'(sum) >= lvl4;
      for (int e = 0; e < NUM_CORNERS; e++) begin
         num = (VB+1)'(level_ff) - (VB+1)'(s1_v_ff[e]);
         den = (VB+1)'(s1_v_ff[(e+1)%4]) - (VB+1)'(s1_v_ff[e]);
         if (den < 0) begin
            num = -num;
            den = -den;
         end
         if (den == 0) begin
            s2_side_in.mode[e] = FM_HALF;
         end else if (num <= 0) begin
            s2_side_in.mode[e] = FM_ZERO;
         end else if (num >= den) begin
            s2_side_in.mode[e] = FM_ONE;
         end else begin
            s2_side_in.mode[e] = FM_DIV;
         end
         s2_num_in[e] = num[VB-1:0];
         s2_den_in[e] = den[VB-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (en) begin
         s2_vld_ff <= s1_vld_ff;
      end
      if (en) begin
         s2_side_ff <= s2_side_in;
         s2_num_ff  <= s2_num_in;
         s2_den_ff  <= s2_den_in;
      end
   end

   // Divider stages, side data travels alongside.
   logic [FB-1:0] quo [4];
   for (genvar e = 0; e < NUM_CORNERS; e++) begin : g_div
      msq_div_pipe #(.VB(VB), .FB(FB)) u_div (
         .clock (clock),
         .en_i  (en),
         .num_i (s2_num_ff[e]),
         .den_i (s2_den_ff[e]),
         .quo_o (quo[e])
      );
   end

   logic     dv_vld_ff  [FB];
   side_type dv_side_ff [FB];

   always_ff @(posedge clock) begin
      for (int k = 0; k < FB; k++) begin
         if (reset) begin
            dv_vld_ff[k] <= 1'b0;
         end else if (en) begin
            dv_vld_ff[k] <= (k == 0) ? s2_vld_ff : dv_vld_ff[k-1];
         end
         if (en) begin
            dv_side_ff[k] <= (k == 0) ? s2_side_ff : dv_side_ff[k-1];
         end
      end
   end

   // Multiply stage: fraction times the edge length along its moving axis.
   logic     m_vld_ff;
   side_type m_side_ff;
   logic [PW-1:0] m_prod_ff [4];
   logic [PW-1:0] m_prod_in [4];
   logic [CB-1:0] m_from_ff [4];
   logic [CB-1:0] m_from_in [4];
   logic [3:0]    m_up_ff, m_up_in;

   always_comb begin
      side_type sd;
      logic [FB:0]   f;
      logic [CB-1:0] to, mag;
      sd = dv_side_ff[FB-1];
      for (int e = 0; e < NUM_CORNERS; e++) begin
         case (sd.mode[e])
            FM_ZERO: f = '0;
            FM_HALF: f = (FB+1)'(1) << (FB - 1);
            FM_ONE:  f = (FB+1)'(1) << FB;
            FM_DIV:  f = {1'b0, quo[e]};
            default: f = '0;
         endcase
         // Bottom and top edges move in x, right and left edges in y.
         case (e)
            0: begin m_from_in[e] = sd.crd[0]; to = sd.crd[1]; end
            1: begin m_from_in[e] = sd.crd[2]; to = sd.crd[3]; end
            2: begin m_from_in[e] = sd.crd[1]; to = sd.crd[0]; end
            default: begin m_from_in[e] = sd.crd[3]; to = sd.crd[2]; end
         endcase
         m_up_in[e] = to >= m_from_in[e];
         mag = m_up_in[e] ? to - m_from_in[e] : m_from_in[e] - to;
         m_prod_in[e] = PW'(f) * PW'(mag);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_vld_ff <= 1'b0;
      end else if (en) begin
         m_vld_ff <= dv_vld_ff[FB-1];
      end
      if (en) begin
         m_side_ff <= dv_side_ff[FB-1];
         m_prod_ff <= m_prod_in;
         m_from_ff <= m_from_in;
         m_up_ff   <= m_up_in;
      end
   end

   // Placement stage: round the offset and apply it.
   logic     p_vld_ff;
   side_type p_side_ff;
   logic [CB-1:0] p_ip_ff [4];
   logic [CB-1:0] p_ip_in [4];

   always_comb begin
      logic [PW-1:0] rnd;
      logic [CB-1:0] off;
      for (int e = 0; e < NUM_CORNERS; e++) begin
         rnd = m_prod_ff[e] + (PW'(1) << (FB - 1));
         off = rnd[FB +: CB];
         p_ip_in[e] = m_up_ff[e] ? m_from_ff[e] + off : m_from_ff[e] - off;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_vld_ff <= 1'b0;
      end else if (en) begin
         p_vld_ff <= m_vld_ff;
      end
      if (en) begin
         p_side_ff <= m_side_ff;
         p_ip_ff   <= p_ip_in;
      end
   end

   // Segment stage: pick edge pairs, order endpoints, drop empty segments.
   // A point packs x above y, so a plain compare gives the point order.
   logic g_vld_ff;
   logic g_sup_ff;
   logic [2*CB-1:0] g_a0_ff, g_a1_ff, g_b0_ff, g_b1_ff;
   logic [2*CB-1:0] g_a0_in, g_a1_in, g_b0_in, g_b1_in;
   logic g_av_ff, g_bv_ff, g_av_in, g_bv_in;

   always_comb begin
      logic [2*CB-1:0] pt [4];
      logic [2*CB-1:0] ra0, ra1, rb0, rb1;
      logic [3:0] cr;
      logic [2:0] nc;
      logic [1:0] lo, hi;
      logic join01;
      side_type sd;
      sd = p_side_ff;
      pt[0] = {p_ip_ff[0], sd.crd[2]};
      pt[1] = {sd.crd[1], p_ip_ff[1]};
      pt[2] = {p_ip_ff[2], sd.crd[3]};
      pt[3] = {sd.crd[0], p_ip_ff[3]};
      nc = '0;
      lo = '0;
      hi = '0;
      for (int e = 0; e < NUM_CORNERS; e++) begin
         cr[e] = sd.hi[e] ^ sd.hi[(e+1)%4];
         nc = nc + 3'(cr[e]);
         if (cr[e]) hi = 2'(e);
      end
      for (int e = NUM_CORNERS - 1; e >= 0; e--) begin
         if (cr[e]) lo = 2'(e);
      end
      join01 = (sd.hi == 4'b0101 && sd.chi) || (sd.hi == 4'b1010 && !sd.chi);
      if (nc == 3'd4) begin
         if (join01) begin
            ra0 = pt[0]; ra1 = pt[1]; rb0 = pt[2]; rb1 = pt[3];
         end else begin
            ra0 = pt[3]; ra1 = pt[0]; rb0 = pt[1]; rb1 = pt[2];
         end
      end else begin
         ra0 = pt[lo]; ra1 = pt[hi]; rb0 = pt[lo]; rb1 = pt[hi];
      end
      g_a0_in = (ra1 < ra0) ? ra1 : ra0;
      g_a1_in = (ra1 < ra0) ? ra0 : ra1;
      g_b0_in = (rb1 < rb0) ? rb1 : rb0;
      g_b1_in = (rb1 < rb0) ? rb0 : rb1;
      g_av_in = sd.sup && (nc == 3'd2 || nc == 3'd4) && (ra0 != ra1);
      g_bv_in = sd.sup && nc == 3'd4 && (rb0 != rb1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g_vld_ff <= 1'b0;
      end else if (en) begin
         g_vld_ff <= p_vld_ff;
      end
      if (en) begin
         g_sup_ff <= p_side_ff.sup;
         g_a0_ff  <= g_a0_in;
         g_a1_ff  <= g_a1_in;
         g_b0_ff  <= g_b0_in;
         g_b1_ff  <= g_b1_in;
         g_av_ff  <= g_av_in;
         g_bv_ff  <= g_bv_in;
      end
   end

   // Output stage: remove a repeated segment and pack the slots.
   logic [OUT_W-1:0] rsp_data_ff, rsp_data_in;

   always_comb begin
      logic [2*CB-1:0] sa0, sa1, sb0, sb1;
      logic [1:0] n;
      sa0 = '0; sa1 = '0; sb0 = '0; sb1 = '0;
      n = '0;
      if (g_av_ff && g_bv_ff) begin
         sa0 = g_a0_ff;
         sa1 = g_a1_ff;
         if (g_a0_ff == g_b0_ff && g_a1_ff == g_b1_ff) begin
            n = 2'd1;
         end else begin
            sb0 = g_b0_ff;
            sb1 = g_b1_ff;
            n = 2'd2;
         end
      end else if (g_av_ff) begin
         sa0 = g_a0_ff;
         sa1 = g_a1_ff;
         n = 2'd1;
      end else if (g_bv_ff) begin
         sa0 = g_b0_ff;
         sa1 = g_b1_ff;
         n = 2'd1;
      end
      rsp_data_in = '0;
      rsp_data_in[0 +: 8*CB] = {sb1[CB-1:0], sb1[2*CB-1:CB], sb0[CB-1:0], sb0[2*CB-1:CB],
                                sa1[CB-1:0], sa1[2*CB-1:CB], sa0[CB-1:0], sa0[2*CB-1:CB]};
      rsp_data_in[8*CB +: 2] = n;
      rsp_data_in[8*CB + 2]  = g_sup_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         rsp_vld_ff <= g_vld_ff;
      end
      if (en) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tdata = rsp_data_ff;

endmodule

`default_nettype wire
